// ===== design/txc_pkg.sv =====
// Package for the text console character writer: geometry, field widths,
// command and character codes, and the sequencer state type.
// No dependencies; every other design file refers to it by scoped names.
package txc_pkg;

    // Screen geometry and derived widths
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Fixed widths of the channel fields
    localparam int CMD_W    = 3;
    localparam int CH_W     = 8;
    localparam int IN_COL_W = 7;
    localparam int IN_ROW_W = 5;
    localparam int OFFSET_W = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = ATTR_W + CH_W;

    // Cell constants
    localparam logic [CH_W-1:0]   BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;
    localparam int                TAB_STOP   = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // Character codes with a cursor action
    localparam logic [CH_W-1:0] CH_NUL = 8'd0;
    localparam logic [CH_W-1:0] CH_BS  = 8'd8;
    localparam logic [CH_W-1:0] CH_TAB = 8'd9;
    localparam logic [CH_W-1:0] CH_LF  = 8'd10;
    localparam logic [CH_W-1:0] CH_CR  = 8'd13;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_WR_BLANK,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_BLANK,
        ST_RD_ISSUE,
        ST_FINISH
    } state_t;

endpackage

// ===== design/txc_ifs.sv =====
// Channel interfaces of the text console: command input, result output and
// the attribute write port. Depends on txc_pkg for the field widths.

interface txc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [txc_pkg::CMD_W-1:0]     cmd;
    logic [txc_pkg::CH_W-1:0]      ch;
    logic [txc_pkg::IN_COL_W-1:0]  col;
    logic [txc_pkg::IN_ROW_W-1:0]  row;

    modport source (output valid, cmd, ch, col, row, input ready);
    modport sink   (input valid, cmd, ch, col, row, output ready);
endinterface

interface txc_res_if;
    logic                          valid;
    logic                          ready;
    logic [txc_pkg::IN_COL_W-1:0]  cursor_col;
    logic [txc_pkg::IN_ROW_W-1:0]  cursor_row;
    logic [txc_pkg::OFFSET_W-1:0]  cursor_index;
    logic [txc_pkg::CH_W-1:0]      cell_char;
    logic [txc_pkg::ATTR_W-1:0]    cell_attr;

    modport source (output valid, cursor_col, cursor_row, cursor_index, cell_char,
                    cell_attr, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_index, cell_char,
                    cell_attr, output ready);
endinterface

interface txc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [txc_pkg::ATTR_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/text_console_char_writer.sv =====
// Text console character writer: screen store, cursor and command sequencer.
// Depends on txc_pkg and the channel interfaces in txc_ifs.sv.
//
// One command is taken at a time; the block lowers cmd_ch.ready until the
// command is finished and its result sits in the output register. A backspace
// that moves the cursor also blanks the cell it lands on. Commands that touch
// many cells (a put that scrolls, a clear, a delete) are paced by the screen
// memory under one address counter, and a delete at the last cell of the screen
// does nothing. After reset a clearing pass writes blanks with attribute 15
// before the first command is taken; attribute writes are taken at any time,
// one per cycle.
module text_console_char_writer
(
    input  logic            clk,
    input  logic            rst_n,
    txc_cmd_if.sink         cmd_ch,
    txc_res_if.source       res_ch,
    txc_cfg_if.sink         cfg
);

    localparam int CW1 = txc_pkg::COL_W + 1;

    // Screen memory
    logic [txc_pkg::CELL_W-1:0] mem [txc_pkg::CELLS];
    logic [txc_pkg::CELL_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic                        mem_re;
    logic [txc_pkg::ADDR_W-1:0]  mem_waddr;
    logic [txc_pkg::ADDR_W-1:0]  mem_raddr;
    logic [txc_pkg::CELL_W-1:0]  mem_wdata;

    // Control and datapath registers
    txc_pkg::state_t            state_reg, state_next;
    logic [txc_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [txc_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [txc_pkg::COL_W-1:0]  pos_col_reg, pos_col_next;
    logic [txc_pkg::ROW_W-1:0]  pos_row_reg, pos_row_next;
    logic [txc_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [txc_pkg::CH_W-1:0]   ch_reg, ch_next;
    logic [txc_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic [txc_pkg::ADDR_W-1:0] end_reg, end_next;
    logic [txc_pkg::ATTR_W-1:0] attr_reg;

    // Result register
    logic                          res_valid_reg, res_valid_next;
    logic [txc_pkg::IN_COL_W-1:0]  res_col_reg, res_col_next;
    logic [txc_pkg::IN_ROW_W-1:0]  res_row_reg, res_row_next;
    logic [txc_pkg::OFFSET_W-1:0]  res_off_reg, res_off_next;
    logic [txc_pkg::CH_W-1:0]      res_char_reg, res_char_next;
    logic [txc_pkg::ATTR_W-1:0]    res_attr_reg, res_attr_next;

    // Shared address unit
    logic [txc_pkg::COL_W-1:0]  sel_col;
    logic [txc_pkg::ROW_W-1:0]  sel_row;
    logic [txc_pkg::ADDR_W-1:0] unit_addr;

    // Decode signals
    logic                       in_fire;
    logic                       res_free;
    logic [txc_pkg::COL_W-1:0]  sat_col;
    logic [txc_pkg::ROW_W-1:0]  sat_row;
    logic                       del_skip;
    logic                       last_row;
    logic [CW1-1:0]             col_adv;
    logic                       col_wrap;
    logic                       put_scroll;
    logic                       put_blank;
    logic [txc_pkg::CELL_W-1:0] blank_cell;

    assign cmd_ch.ready = (state_reg == txc_pkg::ST_IDLE);
    assign in_fire    = cmd_ch.valid && cmd_ch.ready;
    assign res_free   = !res_valid_reg || res_ch.ready;
    assign blank_cell = {attr_reg, txc_pkg::BLANK_CHAR};
    assign cfg.ready  = 1'b1;

    // Saturate the input position to the screen
    assign sat_col = (int'(cmd_ch.col) > txc_pkg::COLS - 1) ?
                     txc_pkg::COL_W'(txc_pkg::COLS - 1) : txc_pkg::COL_W'(cmd_ch.col);
    assign sat_row = (int'(cmd_ch.row) > txc_pkg::ROWS - 1) ?
                     txc_pkg::ROW_W'(txc_pkg::ROWS - 1) : txc_pkg::ROW_W'(cmd_ch.row);

    // Address unit: row * COLS + col, for the cursor or the read position
    assign sel_col   = (state_reg == txc_pkg::ST_RD_ISSUE) ? pos_col_reg : cur_col_reg;
    assign sel_row   = (state_reg == txc_pkg::ST_RD_ISSUE) ? pos_row_reg : cur_row_reg;
    assign unit_addr = txc_pkg::ADDR_W'(sel_row) * txc_pkg::ADDR_W'(txc_pkg::COLS)
                     + txc_pkg::ADDR_W'(sel_col);

    // Delete does nothing at the last cell of the screen
    assign del_skip = (int'(cur_col_reg) >= txc_pkg::COLS - 1) &&
                      (int'(cur_row_reg) >= txc_pkg::ROWS - 1);
    assign last_row = (int'(cur_row_reg) >= txc_pkg::ROWS - 1);

    // Column after a tab or a stored character, and the wrap check
    assign col_adv  = (ch_reg == txc_pkg::CH_TAB) ?
                      ((CW1'(cur_col_reg) + CW1'(txc_pkg::TAB_STOP))
                       & ~CW1'(txc_pkg::TAB_STOP - 1)) :
                      (CW1'(cur_col_reg) + CW1'(1));
    assign col_wrap = (col_adv >= CW1'(txc_pkg::COLS));

    // Classify the character for the sequencer
    always_comb
    begin
        put_scroll = 1'b0;
        put_blank  = 1'b0;
        unique case (ch_reg)
            txc_pkg::CH_NUL, txc_pkg::CH_CR: ;
            txc_pkg::CH_LF:  put_scroll = last_row;
            txc_pkg::CH_BS:  put_blank  = (cur_col_reg != '0) || (cur_row_reg != '0);
            default:         put_scroll = col_wrap && last_row;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            txc_pkg::ST_INIT:
                if (cnt_reg == txc_pkg::ADDR_W'(txc_pkg::CELLS - 1))
                    state_next = txc_pkg::ST_IDLE;
            txc_pkg::ST_IDLE:
                if (in_fire)
                begin
                    unique case (cmd_ch.cmd)
                        txc_pkg::CMD_PUT, txc_pkg::CMD_SETPOS:
                            state_next = txc_pkg::ST_PUT;
                        txc_pkg::CMD_CLEAR:
                            state_next = txc_pkg::ST_BLANK;
                        txc_pkg::CMD_DELETE:
                            state_next = del_skip ? txc_pkg::ST_FINISH : txc_pkg::ST_DEL_RD;
                        txc_pkg::CMD_READ:
                            state_next = txc_pkg::ST_RD_ISSUE;
                        default:
                            state_next = txc_pkg::ST_FINISH;
                    endcase
                end
            txc_pkg::ST_PUT:
                if (put_scroll)
                    state_next = txc_pkg::ST_SCR_RD;
                else if (put_blank)
                    state_next = txc_pkg::ST_WR_BLANK;
                else
                    state_next = txc_pkg::ST_FINISH;
            txc_pkg::ST_WR_BLANK:
                state_next = txc_pkg::ST_FINISH;
            txc_pkg::ST_SCR_RD:
                if (cnt_reg == txc_pkg::ADDR_W'(txc_pkg::CELLS - txc_pkg::COLS))
                    state_next = txc_pkg::ST_BLANK;
                else
                    state_next = txc_pkg::ST_SCR_WR;
            txc_pkg::ST_SCR_WR:
                state_next = txc_pkg::ST_SCR_RD;
            txc_pkg::ST_DEL_RD:
                if (cnt_reg == end_reg)
                    state_next = txc_pkg::ST_BLANK;
                else
                    state_next = txc_pkg::ST_DEL_WR;
            txc_pkg::ST_DEL_WR:
                state_next = txc_pkg::ST_DEL_RD;
            txc_pkg::ST_BLANK:
                if (cnt_reg == end_reg)
                    state_next = txc_pkg::ST_FINISH;
            txc_pkg::ST_RD_ISSUE:
                state_next = txc_pkg::ST_FINISH;
            txc_pkg::ST_FINISH:
                if (res_free)
                    state_next = txc_pkg::ST_IDLE;
            default:
                state_next = txc_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        pos_col_next   = pos_col_reg;
        pos_row_next   = pos_row_reg;
        cmd_next       = cmd_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_raddr      = cnt_reg;
        mem_wdata      = blank_cell;
        res_valid_next = res_valid_reg && !res_ch.ready;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_off_next   = res_off_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;

        unique case (state_reg)
            // Blank the store with the reset attribute
            txc_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {txc_pkg::RESET_ATTR, txc_pkg::BLANK_CHAR};
                cnt_next  = cnt_reg + txc_pkg::ADDR_W'(1);
            end
            // Latch the command and set up its sweep
            txc_pkg::ST_IDLE:
                if (in_fire)
                begin
                    cmd_next     = cmd_ch.cmd;
                    ch_next      = cmd_ch.ch;
                    pos_col_next = sat_col;
                    pos_row_next = sat_row;
                    if (cmd_ch.cmd == txc_pkg::CMD_SETPOS)
                    begin
                        cur_col_next = sat_col;
                        cur_row_next = sat_row;
                    end
                    if (cmd_ch.cmd == txc_pkg::CMD_CLEAR)
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        cnt_next     = '0;
                        end_next     = txc_pkg::ADDR_W'(txc_pkg::CELLS - 1);
                    end
                    if (cmd_ch.cmd == txc_pkg::CMD_DELETE)
                    begin
                        cnt_next = unit_addr;
                        end_next = unit_addr + txc_pkg::ADDR_W'(txc_pkg::COLS - 1)
                                 - txc_pkg::ADDR_W'(cur_col_reg);
                    end
                end
            // Store the character and move the cursor
            txc_pkg::ST_PUT:
            begin
                unique case (ch_reg)
                    txc_pkg::CH_NUL: ;
                    txc_pkg::CH_CR:
                        cur_col_next = '0;
                    txc_pkg::CH_LF:
                        if (!last_row)
                        begin
                            cur_row_next = cur_row_reg + txc_pkg::ROW_W'(1);
                            cur_col_next = '0;
                        end
                    txc_pkg::CH_BS:
                        if (cur_col_reg == '0)
                        begin
                            if (cur_row_reg != '0)
                            begin
                                cur_row_next = cur_row_reg - txc_pkg::ROW_W'(1);
                                cur_col_next = txc_pkg::COL_W'(txc_pkg::COLS - 1);
                            end
                        end
                        else
                            cur_col_next = cur_col_reg - txc_pkg::COL_W'(1);
                    default:
                    begin
                        if (ch_reg != txc_pkg::CH_TAB)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = unit_addr;
                            mem_wdata = {attr_reg, ch_reg};
                        end
                        if (col_wrap)
                        begin
                            cur_col_next = '0;
                            if (!last_row)
                                cur_row_next = cur_row_reg + txc_pkg::ROW_W'(1);
                        end
                        else
                            cur_col_next = txc_pkg::COL_W'(col_adv);
                    end
                endcase
                // Scroll leaves the cursor at the start of the bottom row
                if (put_scroll)
                begin
                    cur_col_next = '0;
                    cur_row_next = txc_pkg::ROW_W'(txc_pkg::ROWS - 1);
                    cnt_next     = '0;
                    end_next     = txc_pkg::ADDR_W'(txc_pkg::CELLS - 1);
                end
            end
            // Blank the cell under the cursor after a backspace
            txc_pkg::ST_WR_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = unit_addr;
            end
            // Copy one row up: read the cell below
            txc_pkg::ST_SCR_RD:
                if (cnt_reg != txc_pkg::ADDR_W'(txc_pkg::CELLS - txc_pkg::COLS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + txc_pkg::ADDR_W'(txc_pkg::COLS);
                end
            txc_pkg::ST_SCR_WR, txc_pkg::ST_DEL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                cnt_next  = cnt_reg + txc_pkg::ADDR_W'(1);
            end
            // Shift the row left: read the right neighbor
            txc_pkg::ST_DEL_RD:
                if (cnt_reg != end_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + txc_pkg::ADDR_W'(1);
                end
            // Blank cells up to the end address
            txc_pkg::ST_BLANK:
            begin
                mem_we = 1'b1;
                if (cnt_reg != end_reg)
                    cnt_next = cnt_reg + txc_pkg::ADDR_W'(1);
            end
            txc_pkg::ST_RD_ISSUE:
            begin
                mem_re    = 1'b1;
                mem_raddr = unit_addr;
            end
            // Load the result once the output register is free
            txc_pkg::ST_FINISH:
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_col_next   = txc_pkg::IN_COL_W'(cur_col_reg);
                    res_row_next   = txc_pkg::IN_ROW_W'(cur_row_reg);
                    res_off_next   = txc_pkg::OFFSET_W'(unit_addr);
                    if (cmd_reg == txc_pkg::CMD_READ)
                    begin
                        res_char_next = rd_data_reg[txc_pkg::CH_W-1:0];
                        res_attr_next = rd_data_reg[txc_pkg::CELL_W-1:txc_pkg::CH_W];
                    end
                    else
                    begin
                        res_char_next = '0;
                        res_attr_next = '0;
                    end
                end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= txc_pkg::ST_INIT;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cnt_reg       <= '0;
            end_reg       <= '0;
            attr_reg      <= txc_pkg::RESET_ATTR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
                attr_reg <= cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_col_reg  <= pos_col_next;
        pos_row_reg  <= pos_row_next;
        cmd_reg      <= cmd_next;
        ch_reg       <= ch_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_off_reg  <= res_off_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Drive the result channel
    assign res_ch.valid        = res_valid_reg;
    assign res_ch.cursor_col   = res_col_reg;
    assign res_ch.cursor_row   = res_row_reg;
    assign res_ch.cursor_index = res_off_reg;
    assign res_ch.cell_char    = res_char_reg;
    assign res_ch.cell_attr    = res_attr_reg;

endmodule

// ===== design/txc_checker.sv =====
// Port-level checks for the text console character writer, with the bind
// that attaches them. Depends on txc_pkg and text_console_char_writer.
module txc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [txc_pkg::IN_COL_W-1:0]  cursor_col,
    input logic [txc_pkg::IN_ROW_W-1:0]  cursor_row,
    input logic [txc_pkg::OFFSET_W-1:0]  cursor_index
);

    // Hold a result until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // Go busy after each command transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while previous one is in progress");

    // Keep the reported cursor on the screen
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cursor_col) < txc_pkg::COLS) &&
                      (int'(cursor_row) < txc_pkg::ROWS))
        else $error("cursor reported off screen");

    // Match the linear position to the reported row and column
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_index ==
            txc_pkg::OFFSET_W'(int'(cursor_row) * txc_pkg::COLS + int'(cursor_col)))
        else $error("cursor index disagrees with row and column");

endmodule

bind text_console_char_writer txc_checker u_txc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_ch.valid),
    .in_ready     (cmd_ch.ready),
    .out_valid    (res_ch.valid),
    .out_ready    (res_ch.ready),
    .cursor_col   (res_ch.cursor_col),
    .cursor_row   (res_ch.cursor_row),
    .cursor_index (res_ch.cursor_index)
);

// ===== bench/text_console_char_writer_tb.sv =====
// Self-checking testbench for text_console_char_writer: commands are driven
// through txc_cmd_if, results are checked against a predictor of the screen.
// Depends on txc_pkg, the channel interfaces in txc_ifs.sv and the top level.
`timescale 1ns / 100ps

module text_console_char_writer_tb;

    typedef struct packed {
        logic [txc_pkg::CMD_W-1:0]    cmd;
        logic [txc_pkg::CH_W-1:0]     ch;
        logic [txc_pkg::IN_COL_W-1:0] col;
        logic [txc_pkg::IN_ROW_W-1:0] row;
    } console_cmd_t;

    typedef struct packed {
        logic [txc_pkg::IN_COL_W-1:0] cursor_col;
        logic [txc_pkg::IN_ROW_W-1:0] cursor_row;
        logic [txc_pkg::OFFSET_W-1:0] cursor_index;
        logic [txc_pkg::CH_W-1:0]     cell_char;
        logic [txc_pkg::ATTR_W-1:0]   cell_attr;
    } console_res_t;

    // Command values with no defined action
    localparam logic [txc_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [txc_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    localparam int STORE_DEPTH     = 4096;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    // The limit covers a put that scrolls on every item
    localparam int CYCLE_LIMIT     = 30000000;

    logic clk;
    logic rst_n;

    txc_cmd_if cmd_ch();
    txc_res_if res_ch();
    txc_cfg_if cfg();

    text_console_char_writer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch),
        .cfg    (cfg)
    );

    // Stimulus store, filled by the sequence block, drained by the driver
    console_cmd_t stim_mem [STORE_DEPTH];
    int           stim_total = 0;
    int           next_issue = 0;
    console_cmd_t offered_cmd;

    // Predicted results, written at command transfer, read at result transfer
    console_res_t expected_mem [STORE_DEPTH];
    int           accepted_total = 0;
    int           checked_total  = 0;
    int           mismatch_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int hold_off_asked  = 0;
    int hold_off_served = 0;
    int hold_off_left   = 0;

    int cycle_count = 0;

    // Shadow of the screen store, cursor and attribute register
    logic [txc_pkg::CELL_W-1:0] shadow_cells [txc_pkg::CELLS];
    int                         shadow_col;
    int                         shadow_row;
    logic [txc_pkg::ATTR_W-1:0] shadow_attr;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [txc_pkg::CELL_W-1:0] blank_word();
        return {shadow_attr, txc_pkg::BLANK_CHAR};
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < txc_pkg::CELLS; i++)
            shadow_cells[i] = blank_word();
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Move rows up by one, blank the bottom row, park the cursor there
    function automatic void scroll_shadow();
        for (int i = 0; i < txc_pkg::CELLS - txc_pkg::COLS; i++)
            shadow_cells[i] = shadow_cells[i + txc_pkg::COLS];
        for (int i = txc_pkg::CELLS - txc_pkg::COLS; i < txc_pkg::CELLS; i++)
            shadow_cells[i] = blank_word();
        shadow_row = txc_pkg::ROWS - 1;
        shadow_col = 0;
    endfunction

    function automatic void put_shadow_char(input logic [txc_pkg::CH_W-1:0] c);
        case (c)
            txc_pkg::CH_TAB:
                shadow_col = (shadow_col + txc_pkg::TAB_STOP) & ~(txc_pkg::TAB_STOP - 1);
            txc_pkg::CH_CR:  shadow_col = 0;
            txc_pkg::CH_LF:
            begin
                if (shadow_row >= txc_pkg::ROWS - 1)
                    scroll_shadow();
                else
                    shadow_row++;
                shadow_col = 0;
            end
            txc_pkg::CH_BS:
            begin
                // Nothing to erase at home
                if (shadow_col != 0 || shadow_row != 0)
                begin
                    if (shadow_col == 0)
                    begin
                        shadow_row--;
                        shadow_col = txc_pkg::COLS - 1;
                    end
                    else
                    begin
                        shadow_col--;
                    end
                    shadow_cells[shadow_row * txc_pkg::COLS + shadow_col] = blank_word();
                end
            end
            txc_pkg::CH_NUL: ;
            default:
            begin
                shadow_cells[shadow_row * txc_pkg::COLS + shadow_col] = {shadow_attr, c};
                shadow_col++;
            end
        endcase
        // Wrap past the last column, scroll past the bottom row
        if (shadow_col >= txc_pkg::COLS)
        begin
            shadow_row++;
            shadow_col = 0;
        end
        if (shadow_row >= txc_pkg::ROWS)
            scroll_shadow();
    endfunction

    // Apply one command to the shadow and return the result it produces
    function automatic console_res_t predict_console(input console_cmd_t item);
        console_res_t               res;
        logic [txc_pkg::CELL_W-1:0] cell_word;
        int                         c;
        int                         r;
        int                         base;
        c = (item.col > txc_pkg::COLS - 1) ? txc_pkg::COLS - 1 : int'(item.col);
        r = (item.row > txc_pkg::ROWS - 1) ? txc_pkg::ROWS - 1 : int'(item.row);
        res = '0;
        case (item.cmd)
            txc_pkg::CMD_PUT:
                put_shadow_char(item.ch);
            txc_pkg::CMD_SETPOS:
            begin
                shadow_col = c;
                shadow_row = r;
                put_shadow_char(item.ch);
            end
            txc_pkg::CMD_CLEAR:
                clear_shadow();
            txc_pkg::CMD_DELETE:
            begin
                // Delete at the last cell of the screen does nothing
                if (!(shadow_col >= txc_pkg::COLS - 1 && shadow_row >= txc_pkg::ROWS - 1))
                begin
                    base = shadow_row * txc_pkg::COLS;
                    for (int k = shadow_col; k < txc_pkg::COLS - 1; k++)
                        shadow_cells[base + k] = shadow_cells[base + k + 1];
                    shadow_cells[base + txc_pkg::COLS - 1] = blank_word();
                end
            end
            txc_pkg::CMD_READ:
            begin
                cell_word = shadow_cells[r * txc_pkg::COLS + c];
                res.cell_char = cell_word[txc_pkg::CH_W-1:0];
                res.cell_attr = cell_word[txc_pkg::CELL_W-1:txc_pkg::CH_W];
            end
            default: ;
        endcase
        res.cursor_col   = txc_pkg::IN_COL_W'(shadow_col);
        res.cursor_row   = txc_pkg::IN_ROW_W'(shadow_row);
        res.cursor_index = txc_pkg::OFFSET_W'(shadow_row * txc_pkg::COLS + shadow_col);
        return res;
    endfunction

    function automatic bit field_ok(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Driver: offer pending commands, predict each one at its transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd   <= '0;
            cmd_ch.ch    <= '0;
            cmd_ch.col   <= '0;
            cmd_ch.row   <= '0;
            clear_shadow();
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_mem[accepted_total] <= predict_console(offered_cmd);
                accepted_total <= accepted_total + 1;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (next_issue < stim_total && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_cmd = stim_mem[next_issue];
                    next_issue++;
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.cmd   <= offered_cmd.cmd;
                    cmd_ch.ch    <= offered_cmd.ch;
                    cmd_ch.col   <= offered_cmd.col;
                    cmd_ch.row   <= offered_cmd.row;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        console_res_t want;
        console_res_t got;
        bit           ok;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.cursor_col, res_ch.cursor_row, res_ch.cursor_index,
                        res_ch.cell_char, res_ch.cell_attr};
                if (checked_total >= accepted_total)
                begin
                    $error("result transfer with no command outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_mem[checked_total];
                    ok = 1'b1;
                    ok &= field_ok("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
                    ok &= field_ok("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
                    ok &= field_ok("cursor_index", 16'(want.cursor_index),
                                   16'(got.cursor_index));
                    ok &= field_ok("cell_char", 16'(want.cell_char), 16'(got.cell_char));
                    ok &= field_ok("cell_attr", 16'(want.cell_attr), 16'(got.cell_attr));
                    if (!ok)
                        mismatch_count++;
                    checked_total <= checked_total + 1;
                end
            end
            res_ch.ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here on request
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
            hold_off_left <= hold_off_left - 1;
        else if (hold_off_served != hold_off_asked)
        begin
            hold_off_left   <= HOLD_OFF_CYCLES;
            hold_off_served <= hold_off_served + 1;
        end
    end

    // Cycle counter and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("text_console_char_writer_tb: FAIL");
        $finish;
    end

    task automatic push_item(input logic [txc_pkg::CMD_W-1:0] cmd,
                             input logic [txc_pkg::CH_W-1:0] ch,
                             input logic [txc_pkg::IN_COL_W-1:0] col,
                             input logic [txc_pkg::IN_ROW_W-1:0] row);
        stim_mem[stim_total] = '{cmd, ch, col, row};
        stim_total++;
    endtask

    function automatic logic [txc_pkg::CH_W-1:0] pick_char();
        case ($urandom_range(19))
            0:       return txc_pkg::CH_TAB;
            1:       return txc_pkg::CH_CR;
            2:       return txc_pkg::CH_LF;
            3:       return txc_pkg::CH_BS;
            4:       return txc_pkg::CH_NUL;
            default: return txc_pkg::CH_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly puts and moves inside the screen; few clears and scrolls
    task automatic push_random_items(input int count);
        int                           sel;
        logic [txc_pkg::CH_W-1:0]     ch;
        logic [txc_pkg::IN_COL_W-1:0] col;
        logic [txc_pkg::IN_ROW_W-1:0] row;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            ch  = pick_char();
            col = txc_pkg::IN_COL_W'($urandom_range(txc_pkg::COLS - 1));
            row = txc_pkg::IN_ROW_W'($urandom_range(txc_pkg::ROWS - 1));
            if ($urandom_range(9) == 0)
                col = txc_pkg::IN_COL_W'($urandom_range(127, txc_pkg::COLS));
            if ($urandom_range(9) == 0)
                row = txc_pkg::IN_ROW_W'($urandom_range(31, txc_pkg::ROWS));
            if (sel < 45)
                push_item(txc_pkg::CMD_PUT, ch, col, row);
            else if (sel < 70)
                push_item(txc_pkg::CMD_SETPOS, ch, col, row);
            else if (sel < 80)
                push_item(txc_pkg::CMD_READ, txc_pkg::CH_W'($urandom_range(255)),
                          txc_pkg::IN_COL_W'($urandom_range(127)),
                          txc_pkg::IN_ROW_W'($urandom_range(31)));
            else if (sel < 88)
                push_item(txc_pkg::CMD_DELETE, ch, col, row);
            else if (sel < 89)
                push_item(txc_pkg::CMD_CLEAR, ch, col, row);
            else if (sel < 92)
                push_item(txc_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                          ch, col, row);
            else
                push_item(txc_pkg::CMD_PUT, txc_pkg::CH_W'($urandom_range(126, 32)), col, row);
        end
    endtask

    task automatic wait_idle();
        while (accepted_total != stim_total || checked_total != stim_total)
            @(posedge clk);
    endtask

    task automatic write_attr(input logic [txc_pkg::ATTR_W-1:0] value);
        cfg.data  <= value;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        shadow_attr = value;
    endtask

    // Sequence: reset, directed cases, then random phases under each idling mode
    initial
    begin
        rst_n        = 1'b0;
        shadow_attr  = txc_pkg::RESET_ATTR;
        cfg.valid    <= 1'b0;
        cfg.data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: saturation, wrap, scroll, control characters, delete, clear
        write_attr(8'hFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_item(txc_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_PUT, 8'h41, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_SETPOS, 8'h5A, 7'd127, 5'd31);
        push_item(txc_pkg::CMD_READ, 8'h00, 7'd127, 5'd31);
        push_item(txc_pkg::CMD_READ, 8'h00, 7'd79, 5'd23);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_BS, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_BS, 7'd0, 5'd5);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_BS, 7'd10, 5'd5);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_TAB, 7'd3, 5'd2);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_TAB, 7'd75, 5'd2);
        push_item(txc_pkg::CMD_PUT, txc_pkg::CH_CR, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_PUT, txc_pkg::CH_NUL, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_SETPOS, 8'h78, 7'd5, 5'd10);
        push_item(txc_pkg::CMD_PUT, 8'h79, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_NUL, 7'd5, 5'd10);
        push_item(txc_pkg::CMD_DELETE, 8'h00, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_READ, 8'h00, 7'd5, 5'd10);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_NUL, 7'd79, 5'd24);
        push_item(txc_pkg::CMD_DELETE, 8'h00, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_SETPOS, txc_pkg::CH_LF, 7'd0, 5'd24);
        push_item(txc_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_PUT, 8'h01, 7'd0, 5'd0);
        push_item(CMD_UNUSED_FIRST, 8'hFF, 7'd127, 5'd31);
        push_item(CMD_UNUSED_LAST, 8'h00, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_CLEAR, 8'h00, 7'd0, 5'd0);
        push_item(txc_pkg::CMD_READ, 8'h00, 7'd40, 5'd12);
        wait_idle();

        // No idling; the receiver holds off so the block backs up
        write_attr(8'h00);
        push_random_items(450);
        hold_off_asked++;
        wait_idle();

        // Sender mostly idle
        write_attr(txc_pkg::ATTR_W'($urandom_range(255)));
        send_idle_pct = 84;
        push_random_items(450);
        wait_idle();

        // Receiver mostly stalled
        write_attr(txc_pkg::ATTR_W'($urandom_range(255)));
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        push_random_items(450);
        wait_idle();

        // Both sides idle now and then
        write_attr(8'h5A);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        push_random_items(450);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && checked_total == accepted_total)
            $display("text_console_char_writer_tb: PASS");
        else
            $display("text_console_char_writer_tb: FAIL");
        $finish;
    end

endmodule
